// ===== hdl/nnis_pkg.sv =====
// shared types and constants of the nearest-neighbour image scaler
package nnis_pkg;

	// default sizing
	localparam int MAX_DIM_DEF    = 256;
	localparam int PIXEL_BITS_DEF = 32;

	// fixed field widths
	localparam int COORD_W    = 8;
	localparam int LD_PIXEL_W = 32;
	localparam int DIM_REG_W  = 9;
	localparam int STEP_W     = 25;
	localparam int ACC_W      = 24;
	localparam int FRAC_W     = 16;
	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	// configuration port
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;
	localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_STEP_X        = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_STEP_Y        = 3'd4;

	localparam logic [DIM_REG_W-1:0] DIM_RESET  = 9'd1;
	localparam logic [STEP_W-1:0]    STEP_RESET = 25'd65536;

	// command queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = 2;
	localparam int QCNT_W  = 3;

	// configuration registers
	typedef struct packed {
		logic [DIM_REG_W-1:0] source_width;
		logic [DIM_REG_W-1:0] target_width;
		logic [DIM_REG_W-1:0] target_height;
		logic [STEP_W-1:0]    step_x;
		logic [STEP_W-1:0]    step_y;
	} nnis_cfg_t;

	// per-command control carried through the queue
	typedef struct packed {
		logic               is_emit;
		logic               in_range;
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
		logic               frame_done;
	} nnis_meta_t;

	localparam int META_W = $bits(nnis_meta_t);

endpackage

// ===== hdl/nnis_if.sv =====
// stream channels of the scaler: input items and result pixels

interface nnis_in_if;
	logic                               valid;
	logic                               ready;
	logic                               action;
	logic [nnis_pkg::COORD_W-1:0]       load_x;
	logic [nnis_pkg::COORD_W-1:0]       load_y;
	logic [nnis_pkg::LD_PIXEL_W-1:0]    load_pixel;

	modport source (output valid, action, load_x, load_y, load_pixel, input ready);
	modport sink (input valid, action, load_x, load_y, load_pixel, output ready);
endinterface

interface nnis_out_if;
	logic                               valid;
	logic                               ready;
	logic [nnis_pkg::COORD_W-1:0]       out_x;
	logic [nnis_pkg::COORD_W-1:0]       out_y;
	logic [nnis_pkg::LD_PIXEL_W-1:0]    out_pixel;
	logic                               frame_done;

	modport source (output valid, out_x, out_y, out_pixel, frame_done, input ready);
	modport sink (input valid, out_x, out_y, out_pixel, frame_done, output ready);
endinterface

// ===== hdl/nnis_front.sv =====
// front end: accepts items, walks the destination traversal and forms store addresses
module nnis_front #(
	parameter int MAX_DIM    = nnis_pkg::MAX_DIM_DEF,
	parameter int PIXEL_BITS = nnis_pkg::PIXEL_BITS_DEF,
	localparam int AW        = $clog2(MAX_DIM * MAX_DIM)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nnis_pkg::nnis_cfg_t  cfg,
	nnis_in_if.sink              pix_in,
	input  logic                 q_full,
	output logic                 push,
	output nnis_pkg::nnis_meta_t push_meta,
	output logic [AW-1:0]        push_addr,
	output logic [PIXEL_BITS-1:0] push_pixel
);

	localparam int CNT_W  = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int PROD_W = nnis_pkg::COORD_W + DIM_W + 1;
	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int SUM_W  = nnis_pkg::ACC_W + 2;

	logic [CNT_W-1:0]              col_q, row_q;
	logic [nnis_pkg::ACC_W-1:0]    accx_q, accy_q;
	logic [DIM_W-1:0]              sw, tw, th;
	logic [PROD_W-1:0]             sw_w, sx_w, col_w, row_w, addr_full;
	logic                          last_row, last_col;
	logic [SUM_W-1:0]              sumx, sumy;
	logic [nnis_pkg::ACC_W-1:0]    accx_nxt, accy_nxt;

	// zero acts as one, oversized acts as the maximum
	function automatic logic [DIM_W-1:0] eff_dim(input logic [nnis_pkg::DIM_REG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > 32'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	assign sw = eff_dim(cfg.source_width);
	assign tw = eff_dim(cfg.target_width);
	assign th = eff_dim(cfg.target_height);

	// source column from accumulator, clamped below the source width
	always_comb begin
		sw_w = PROD_W'(sw);
		sx_w = PROD_W'(accx_q[nnis_pkg::ACC_W-1:nnis_pkg::FRAC_W]);
		if (sx_w >= sw_w) begin
			sx_w = sw_w - PROD_W'(1);
		end
	end

	// one shared multiplier for load and emit addresses
	assign row_w = pix_in.action ? PROD_W'(accy_q[nnis_pkg::ACC_W-1:nnis_pkg::FRAC_W])
	                             : PROD_W'(pix_in.load_y);
	assign col_w = pix_in.action ? sx_w : PROD_W'(pix_in.load_x);
	assign addr_full = PROD_W'(row_w * sw_w) + col_w;

	// traversal end detection
	assign last_row = ((DIM_W+1)'(row_q) + (DIM_W+1)'(1)) >= (DIM_W+1)'(th);
	assign last_col = ((DIM_W+1)'(col_q) + (DIM_W+1)'(1)) >= (DIM_W+1)'(tw);

	// saturating accumulator steps
	assign sumx = SUM_W'(accx_q) + SUM_W'(cfg.step_x);
	assign sumy = SUM_W'(accy_q) + SUM_W'(cfg.step_y);
	assign accx_nxt = (sumx > SUM_W'(nnis_pkg::ACC_MAX)) ? nnis_pkg::ACC_MAX
	                                                      : sumx[nnis_pkg::ACC_W-1:0];
	assign accy_nxt = (sumy > SUM_W'(nnis_pkg::ACC_MAX)) ? nnis_pkg::ACC_MAX
	                                                      : sumy[nnis_pkg::ACC_W-1:0];

	// handshake into the queue
	assign pix_in.ready = !q_full;
	assign push         = pix_in.valid && !q_full;

	// command built for the back end
	always_comb begin
		push_meta.is_emit    = pix_in.action;
		push_meta.in_range   = (33'(addr_full) < 33'(DEPTH)) &&
		                       (pix_in.action || (col_w < sw_w));
		push_meta.out_x      = nnis_pkg::COORD_W'(col_q);
		push_meta.out_y      = nnis_pkg::COORD_W'(row_q);
		push_meta.frame_done = last_row && last_col;
		push_addr            = AW'(addr_full);
		push_pixel           = pix_in.load_pixel[PIXEL_BITS-1:0];
	end

	// traversal state, advanced by each accepted emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			accx_q <= '0;
			accy_q <= '0;
		end else if (push && pix_in.action) begin
			if (!last_row) begin
				row_q  <= row_q + CNT_W'(1);
				accy_q <= accy_nxt;
			end else begin
				row_q  <= '0;
				accy_q <= '0;
				if (!last_col) begin
					col_q  <= col_q + CNT_W'(1);
					accx_q <= accx_nxt;
				end else begin
					col_q  <= '0;
					accx_q <= '0;
				end
			end
		end
	end

endmodule

// ===== hdl/nnis_queue.sv =====
// short command queue between front and back
module nnis_queue #(
	parameter int W = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [W-1:0]                push_data,
	output logic                        full,
	input  logic                        pop,
	output logic [W-1:0]                pop_data,
	output logic                        empty,
	output logic [nnis_pkg::QCNT_W-1:0] count
);

	logic [W-1:0]                entry_q [nnis_pkg::Q_DEPTH];
	logic [nnis_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [nnis_pkg::QCNT_W-1:0] count_q;

	assign full     = (count_q == nnis_pkg::QCNT_W'(nnis_pkg::Q_DEPTH));
	assign empty    = (count_q == '0);
	assign count    = count_q;
	assign pop_data = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + nnis_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + nnis_pkg::QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + nnis_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - nnis_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/nnis_back.sv =====
// back end: frame store writes and reads, result register
module nnis_back #(
	parameter int MAX_DIM    = nnis_pkg::MAX_DIM_DEF,
	parameter int PIXEL_BITS = nnis_pkg::PIXEL_BITS_DEF,
	localparam int AW        = $clog2(MAX_DIM * MAX_DIM)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  nnis_pkg::nnis_meta_t  cmd_meta,
	input  logic [AW-1:0]         cmd_addr,
	input  logic [PIXEL_BITS-1:0] cmd_pixel,
	output logic                  pop,
	nnis_out_if.source            pix_out
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;

	logic [PIXEL_BITS-1:0] store_mem [DEPTH];
	logic [PIXEL_BITS-1:0] rdata_s1;
	nnis_pkg::nnis_meta_t  meta_s1;
	logic                  valid_s1;
	logic                  wr_en, rd_en;

	// take a command when the result slot is free or leaving
	assign pop   = !q_empty && (!valid_s1 || pix_out.ready);
	assign wr_en = pop && !cmd_meta.is_emit && cmd_meta.in_range;
	assign rd_en = pop && cmd_meta.is_emit;

	// frame store, one access per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[cmd_addr] <= cmd_pixel;
		end
		if (rd_en) begin
			rdata_s1 <= store_mem[cmd_addr];
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1 <= cmd_meta.is_emit;
		end else if (pix_out.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			meta_s1 <= cmd_meta;
		end
	end

	// result beat
	assign pix_out.valid      = valid_s1;
	assign pix_out.out_x      = meta_s1.out_x;
	assign pix_out.out_y      = meta_s1.out_y;
	assign pix_out.frame_done = meta_s1.frame_done;
	assign pix_out.out_pixel  = meta_s1.in_range ? nnis_pkg::LD_PIXEL_W'(rdata_s1)
	                                             : '0;

endmodule

// ===== hdl/nearest_neighbor_image_scaler.sv =====
// Nearest-neighbour scaler: one item accepted per cycle unless the queue is full, and
// one store access per cycle in the back. Emit path: queue slot, then store read into the
// result register. Load items pass the queue slot before the store write; they give no beat.
// Throughput is one item per clock while results are taken, set by the single store port.
// Reset clears traversal counters, accumulators, queue and result valid; registers take
// their reset values; the frame store is not cleared and reads undefined until written.
module nearest_neighbor_image_scaler #(
	parameter int MAX_DIM    = nnis_pkg::MAX_DIM_DEF,
	parameter int PIXEL_BITS = nnis_pkg::PIXEL_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [nnis_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [nnis_pkg::APB_DATA_W-1:0] pwdata,
	output logic [nnis_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	nnis_in_if.sink                         pix_in,
	nnis_out_if.source                      pix_out
);

	localparam int AW = $clog2(MAX_DIM * MAX_DIM);
	localparam int QW = nnis_pkg::META_W + AW + PIXEL_BITS;

	nnis_pkg::nnis_cfg_t          cfg_q;
	logic [nnis_pkg::REG_IDX_W-1:0] reg_idx;
	logic                         cfg_wr;
	logic                         push, pop, q_full, q_empty;
	logic [nnis_pkg::QCNT_W-1:0]  q_count;
	nnis_pkg::nnis_meta_t         push_meta, cmd_meta;
	logic [AW-1:0]                push_addr, cmd_addr;
	logic [PIXEL_BITS-1:0]        push_pixel, cmd_pixel;
	logic [QW-1:0]                q_out;

	// configuration registers
	assign pready  = 1'b1;
	assign reg_idx = paddr[nnis_pkg::APB_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_width  <= nnis_pkg::DIM_RESET;
			cfg_q.target_width  <= nnis_pkg::DIM_RESET;
			cfg_q.target_height <= nnis_pkg::DIM_RESET;
			cfg_q.step_x        <= nnis_pkg::STEP_RESET;
			cfg_q.step_y        <= nnis_pkg::STEP_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				nnis_pkg::REG_SOURCE_WIDTH:
					cfg_q.source_width  <= pwdata[nnis_pkg::DIM_REG_W-1:0];
				nnis_pkg::REG_TARGET_WIDTH:
					cfg_q.target_width  <= pwdata[nnis_pkg::DIM_REG_W-1:0];
				nnis_pkg::REG_TARGET_HEIGHT:
					cfg_q.target_height <= pwdata[nnis_pkg::DIM_REG_W-1:0];
				nnis_pkg::REG_STEP_X:
					cfg_q.step_x        <= pwdata[nnis_pkg::STEP_W-1:0];
				nnis_pkg::REG_STEP_Y:
					cfg_q.step_y        <= pwdata[nnis_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// register read-back
	always_comb begin
		unique case (reg_idx)
			nnis_pkg::REG_SOURCE_WIDTH:  prdata = nnis_pkg::APB_DATA_W'(cfg_q.source_width);
			nnis_pkg::REG_TARGET_WIDTH:  prdata = nnis_pkg::APB_DATA_W'(cfg_q.target_width);
			nnis_pkg::REG_TARGET_HEIGHT: prdata = nnis_pkg::APB_DATA_W'(cfg_q.target_height);
			nnis_pkg::REG_STEP_X:        prdata = nnis_pkg::APB_DATA_W'(cfg_q.step_x);
			nnis_pkg::REG_STEP_Y:        prdata = nnis_pkg::APB_DATA_W'(cfg_q.step_y);
			default:                     prdata = '0;
		endcase
	end

	// front end
	nnis_front #(
		.MAX_DIM    (MAX_DIM),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pix_in     (pix_in),
		.q_full     (q_full),
		.push       (push),
		.push_meta  (push_meta),
		.push_addr  (push_addr),
		.push_pixel (push_pixel)
	);

	// command queue
	nnis_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_meta, push_addr, push_pixel}),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (q_out),
		.empty     (q_empty),
		.count     (q_count)
	);

	assign {cmd_meta, cmd_addr, cmd_pixel} = q_out;

	// back end
	nnis_back #(
		.MAX_DIM    (MAX_DIM),
		.PIXEL_BITS (PIXEL_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.cmd_meta  (cmd_meta),
		.cmd_addr  (cmd_addr),
		.cmd_pixel (cmd_pixel),
		.pop       (pop),
		.pix_out   (pix_out)
	);

	// back end never takes from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("command taken from empty queue");

	// fill level rises on a push without a pop
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (q_count == $past(q_count) + nnis_pkg::QCNT_W'(1)))
		else $error("queue fill level lost a push");

	// back end does not idle with work queued and room for a result
	a_back_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && (!pix_out.valid || pix_out.ready)) |-> pop)
		else $error("back end stalled without cause");

endmodule
